### hw/rtl/vcu_pkg.sv
// ----------------------------------------------------------------------------
// vcu_pkg
// Shared types and constants of the vector clock unit.
// ----------------------------------------------------------------------------
package vcu_pkg;

    localparam int THREAD_ENTRIES = 8;
    localparam int LANE_PORTS     = 8;
    localparam int CLOCK_W        = 32;
    localparam int IDX_W          = $clog2(THREAD_ENTRIES);
    localparam int DIM_W          = $clog2(THREAD_ENTRIES + 1);
    localparam int OWNER_W        = 4;
    localparam int KIND_W         = 3;
    localparam int CFG_W          = 4;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [CLOCK_W-1:0]    CLOCK_MAX  = '1;
    localparam logic [OWNER_W-1:0]    OWNER_NONE = '1;
    localparam logic [CFG_W-1:0]      ACTIVE_COUNT_RESET = CFG_W'(THREAD_ENTRIES);
    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_COUNT  = '0;

    typedef enum logic [KIND_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_INIT  = 3'd1,
        OP_INCR  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_LE    = 3'd5,
        OP_JOIN  = 3'd6,
        OP_COPY  = 3'd7
    } op_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

### hw/rtl/vector_clock_unit.sv
// ----------------------------------------------------------------------------
// vector_clock_unit
// One vector clock of a race detector: per-thread counters plus an owner.
//
// Usage: an item on the input channel (in_valid/in_ready) is one operation
// selected by kind. Each item gives exactly one result on the output channel
// (out_valid/out_ready). The user sets active_count through the APB port at
// offset 0 only while the block is idle; the block does not enforce this.
// Timing: the input is registered when taken, then a small sequencer drives a
// single 33-bit add/compare unit over the entries, one entry per cycle.
// Clear, join, copy and an accepted init take one step per entry below the
// dimension (active_count clamped to 1..8); increment, write, read,
// less-or-equal and a rejected init take one step. The block stays in its
// run state until an item's last step, and in_ready stays low meanwhile.
// The result register frees the sequencer: a new item is taken while the
// last result still waits. If the receiver stalls and a new result is ready,
// the final step holds without touching state until the output register
// drains.
// Reset: all counters zero, no owner, active_count = 8, output empty.
// ----------------------------------------------------------------------------
module vector_clock_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vcu_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [vcu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [vcu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [vcu_pkg::KIND_W-1:0]        kind,
    input  logic [2:0]                        entry_index,
    input  logic [vcu_pkg::CLOCK_W-1:0]       amount,
    input  logic signed [vcu_pkg::OWNER_W-1:0] other_owner,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_0,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_1,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_2,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_3,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_4,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_5,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_6,
    input  logic [vcu_pkg::CLOCK_W-1:0]       other_lane_7,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vcu_pkg::CLOCK_W-1:0]       read_value,
    output logic                              is_ordered,
    output logic signed [vcu_pkg::OWNER_W-1:0] owner_now,
    output logic                              bad_request
);
    import vcu_pkg::*;

    state_t                   state_reg, state_next;
    logic [CFG_W-1:0]         active_count_reg;
    logic [DIM_W-1:0]         dim_eff;
    logic [DIM_W-1:0]         dim_reg;
    op_kind_t                 kind_reg;
    logic [2:0]               idx_reg;
    logic [CLOCK_W-1:0]       amount_reg;
    logic [OWNER_W-1:0]       in_owner_reg;
    logic [OWNER_W-1:0]       in_owner_next;
    logic [CLOCK_W-1:0]       lanes_reg [THREAD_ENTRIES];
    logic [CLOCK_W-1:0]       lane_in   [LANE_PORTS];
    logic [CLOCK_W-1:0]       clocks_reg [THREAD_ENTRIES];
    logic [OWNER_W-1:0]       owner_reg, owner_next;
    logic [IDX_W-1:0]         cnt_reg;

    logic                     out_valid_reg;
    logic [CLOCK_W-1:0]       read_value_reg;
    logic                     is_ordered_reg;
    logic [OWNER_W-1:0]       owner_now_reg;
    logic                     bad_request_reg;

    logic                     accept;
    logic                     cfg_write;
    logic                     step_go;
    logic                     last;
    logic                     bad;
    logic                     sweep;
    logic                     owner_none;
    logic                     idx_out;
    logic                     owner_out;
    logic [IDX_W-1:0]         addr;
    logic [CLOCK_W-1:0]       rd;
    logic [CLOCK_W-1:0]       lane_sel;
    logic                     wr_en;
    logic [CLOCK_W-1:0]       wr_data;
    logic [CLOCK_W-1:0]       res_read;
    logic                     res_ordered;

    logic [CLOCK_W-1:0]       alu_x, alu_y;
    logic                     alu_sub;
    logic [CLOCK_W:0]         alu_sum;
    logic                     alu_carry;

    assign lane_in[0] = other_lane_0;
    assign lane_in[1] = other_lane_1;
    assign lane_in[2] = other_lane_2;
    assign lane_in[3] = other_lane_3;
    assign lane_in[4] = other_lane_4;
    assign lane_in[5] = other_lane_5;
    assign lane_in[6] = other_lane_6;
    assign lane_in[7] = other_lane_7;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_ACTIVE_COUNT);
    assign prdata    = (paddr == ADDR_ACTIVE_COUNT) ?
                       APB_DATA_W'(active_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= ACTIVE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            active_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    // clamp dimension and resolve incoming owner
    always_comb
    begin
        if (active_count_reg == '0)
        begin
            dim_eff = DIM_W'(1);
        end
        else if (DIM_W'(active_count_reg) > DIM_W'(THREAD_ENTRIES))
        begin
            dim_eff = DIM_W'(THREAD_ENTRIES);
        end
        else
        begin
            dim_eff = DIM_W'(active_count_reg);
        end
        if (other_owner[OWNER_W-1] ||
            (int'(other_owner) >= THREAD_ENTRIES))
        begin
            in_owner_next = OWNER_NONE;
        end
        else
        begin
            in_owner_next = other_owner;
        end
    end

    // shared add / compare unit
    assign alu_sum   = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                       + (CLOCK_W + 1)'(alu_sub);
    assign alu_carry = alu_sum[CLOCK_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_go && last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        owner_none  = owner_reg[OWNER_W-1];
        idx_out     = (DIM_W'(idx_reg) >= dim_reg);
        owner_out   = (DIM_W'(owner_reg[IDX_W-1:0]) >= dim_reg);
        sweep       = 1'b0;
        bad         = 1'b0;
        addr        = idx_reg[IDX_W-1:0];
        alu_x       = '0;
        alu_y       = '0;
        alu_sub     = 1'b0;
        wr_en       = 1'b0;
        wr_data     = '0;
        owner_next  = owner_reg;
        res_read    = '0;
        res_ordered = 1'b0;

        case (kind_reg)
            OP_CLEAR, OP_JOIN, OP_COPY:
            begin
                sweep = 1'b1;
                addr  = cnt_reg;
            end
            OP_INIT:
            begin
                bad   = idx_out;
                sweep = !idx_out;
                addr  = cnt_reg;
            end
            OP_INCR, OP_LE:
            begin
                addr = owner_reg[IDX_W-1:0];
            end
            default:
            begin
                addr = idx_reg[IDX_W-1:0];
            end
        endcase

        rd       = clocks_reg[addr];
        lane_sel = lanes_reg[addr];
        last     = !sweep || ((DIM_W'(cnt_reg) + DIM_W'(1)) == dim_reg);

        case (kind_reg)
            OP_CLEAR:
            begin
                wr_en      = 1'b1;
                owner_next = OWNER_NONE;
            end
            OP_INIT:
            begin
                wr_en   = !idx_out;
                wr_data = (cnt_reg == idx_reg[IDX_W-1:0]) ? CLOCK_W'(1) : '0;
                if (!idx_out)
                begin
                    owner_next = OWNER_W'(idx_reg);
                end
            end
            OP_INCR:
            begin
                bad     = owner_none || owner_out;
                alu_x   = rd;
                alu_y   = amount_reg;
                wr_en   = !bad;
                wr_data = alu_carry ? CLOCK_MAX : alu_sum[CLOCK_W-1:0];
            end
            OP_WRITE:
            begin
                bad     = idx_out;
                wr_en   = !idx_out;
                wr_data = amount_reg;
            end
            OP_READ:
            begin
                bad      = idx_out;
                res_read = idx_out ? '0 : rd;
            end
            OP_LE:
            begin
                bad         = !owner_none && owner_out;
                alu_x       = lane_sel;
                alu_y       = rd;
                alu_sub     = 1'b1;
                res_ordered = owner_none || (!owner_out && alu_carry);
            end
            OP_JOIN:
            begin
                alu_x   = lane_sel;
                alu_y   = rd;
                alu_sub = 1'b1;
                wr_en   = 1'b1;
                wr_data = alu_carry ? lane_sel : rd;
                if (owner_none)
                begin
                    owner_next = in_owner_reg;
                end
            end
            OP_COPY:
            begin
                wr_en      = 1'b1;
                wr_data    = lane_sel;
                owner_next = in_owner_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase

        step_go = (state_reg == ST_RUN) && !(last && out_valid_reg && !out_ready);
    end

    assign accept = in_valid && in_ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            owner_reg     <= OWNER_NONE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < THREAD_ENTRIES; i++)
            begin
                clocks_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (step_go && !last)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            if (step_go && wr_en)
            begin
                clocks_reg[addr] <= wr_data;
            end
            if (step_go && last)
            begin
                owner_reg     <= owner_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= op_kind_t'(kind);
            idx_reg      <= entry_index;
            amount_reg   <= amount;
            in_owner_reg <= in_owner_next;
            dim_reg      <= dim_eff;
            for (int i = 0; i < THREAD_ENTRIES; i++)
            begin
                lanes_reg[i] <= lane_in[i];
            end
        end
        if (step_go && last)
        begin
            read_value_reg  <= res_read;
            is_ordered_reg  <= res_ordered;
            owner_now_reg   <= owner_next;
            bad_request_reg <= bad;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign is_ordered  = is_ordered_reg;
    assign owner_now   = owner_now_reg;
    assign bad_request = bad_request_reg;

    a_owner_encoding: assert property (@(posedge clk) disable iff (!rst_n)
        owner_reg[OWNER_W-1] |-> (owner_reg == OWNER_NONE))
        else $error("owner holds a negative code other than none");

    a_cnt_in_dim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (DIM_W'(cnt_reg) < dim_reg))
        else $error("entry counter ran past the dimension");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result appeared without an item in progress");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !in_ready)
        else $error("input taken while an item is in progress");

endmodule
